FILE: sv/hcbp_pkg.sv
// Package for the Huffman code bit packer: field widths, action codes and
// parameter defaults. Depends on nothing; used by the interfaces and the RTL.
package hcbp_pkg;

  // Fixed field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned CODE_W   = 32;  // width of code_bits and of the code field of each table entry
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned BYTE_W   = 8;

  // Pending bits never reach a full byte
  localparam int unsigned PEND_W   = BYTE_W - 1;
  localparam int unsigned PCNT_W   = 3;

  // Longest code the table accepts
  localparam int unsigned MAX_CODE_LEN = 32;

  // Worst case: seven pending bits plus a full-width code
  localparam int unsigned ACC_W     = PEND_W + CODE_W;
  localparam int unsigned MAX_BYTES = ACC_W / BYTE_W;
  localparam int unsigned LJ_W      = MAX_BYTES * BYTE_W + BYTE_W;
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

  // Parameter default
  localparam int unsigned SYMBOLS_DEF = 256;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_e;

endpackage

FILE: sv/hcbp_if.sv
// Valid/ready channels of the Huffman code bit packer: input words and
// output bytes. Depends on hcbp_pkg for field widths.
interface hcbp_in_if;
  logic                           valid;
  logic                           ready;
  logic [hcbp_pkg::ACTION_W-1:0]  action;
  logic [hcbp_pkg::SYMBOL_W-1:0]  symbol;
  logic [hcbp_pkg::CODE_W-1:0]    code_bits;
  logic [hcbp_pkg::LEN_W-1:0]     code_len;

  modport source (output valid, action, symbol, code_bits, code_len, input ready);
  modport sink   (input valid, action, symbol, code_bits, code_len, output ready);
endinterface

interface hcbp_out_if;
  logic                         valid;
  logic                         ready;
  logic [hcbp_pkg::BYTE_W-1:0]  out_byte;
  logic                         last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

FILE: sv/huffman_code_bit_packer.sv
// Huffman code bit packer: code table, pending-bit accumulator and byte
// drain buffer. Depends on hcbp_pkg and the channel interfaces in hcbp_if.sv.
//
// Usage: in_i takes one word per handshake. A load word (action 0) writes the
// code and length of one symbol into the table if the symbol is in range and
// the length is at most 32; an encode word (action 1) appends that symbol's
// code, first bit first, to the accumulator; a flush word (action 2) pads the
// leftover bits with zeros to a byte. out_o carries the completed bytes,
// earliest bit in bit 7, with last_of_run on the final byte caused by a word.
// The first byte of a word passes through the table read register, which
// takes the word at the accepting edge, and then the drain buffer, into which
// the packer moves it once the buffer frees. Throughput: one word per cycle
// while words yield at most one byte and out_o.ready stays high;
// a word that yields N bytes (up to four) holds the drain buffer until its
// last byte leaves, and the next word waits in the table read register
// meanwhile.
// Reset: every table entry reads as length zero until loaded, the accumulator
// is empty and both channels are idle. Nothing sweeps the table after reset.
// Stall: when out_o.ready is low the current byte holds; in_i still takes one
// more word into the read register, then in_i.ready drops.
module huffman_code_bit_packer #(
  parameter int unsigned SYMBOLS = hcbp_pkg::SYMBOLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hcbp_in_if.sink           in_i,
  hcbp_out_if.source        out_o
);

  localparam int unsigned AW    = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned ENT_W = hcbp_pkg::LEN_W + hcbp_pkg::CODE_W;
  localparam int unsigned BW    = hcbp_pkg::BYTE_W;

  // Code table: length and code of each symbol
  logic [ENT_W-1:0]   tab_mem [SYMBOLS];
  logic [SYMBOLS-1:0] tab_vld_q;

  // Read stage
  logic               s1_vld_q;
  logic [hcbp_pkg::ACTION_W-1:0] s1_act_q;
  logic               s1_hit_q;
  logic [ENT_W-1:0]   s1_rd_q;

  // Accumulator and drain buffer
  logic [hcbp_pkg::PEND_W-1:0] pend_q, pend_d;
  logic [hcbp_pkg::PCNT_W-1:0] pcnt_q, pcnt_d;
  logic [BW-1:0]               buf_q [hcbp_pkg::MAX_BYTES];
  logic [BW-1:0]               buf_d [hcbp_pkg::MAX_BYTES];
  logic [hcbp_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  logic            in_acc, in_range, len_ok, is_load, is_encode;
  logic [AW-1:0]   addr;
  logic            buf_free, s1_adv, pop;
  logic [hcbp_pkg::CODE_W-1:0] len_mask;
  logic [hcbp_pkg::CODE_W-1:0] code_masked;

  logic [hcbp_pkg::LEN_W-1:0]  clen;
  logic [hcbp_pkg::CODE_W-1:0] code;
  logic [hcbp_pkg::ACC_W-1:0]  acc;
  logic [hcbp_pkg::LEN_W-1:0]  total;
  logic [hcbp_pkg::LJ_W-1:0]   lj;
  logic [hcbp_pkg::LEN_W-1:0]  lj_shift;

  // Decode the incoming word
  assign addr      = in_i.symbol[AW-1:0];
  assign in_range  = ({1'b0, in_i.symbol} < (hcbp_pkg::SYMBOL_W + 1)'(SYMBOLS));
  assign len_ok    = (in_i.code_len <= hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W)) &&
                     (in_i.code_len <= hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN));
  assign is_load   = (in_i.action == hcbp_pkg::ACT_LOAD);
  assign is_encode = (in_i.action == hcbp_pkg::ACT_ENCODE);
  assign in_acc    = in_i.valid && in_i.ready;

  // Drop code bits above the loaded length
  assign len_mask    = ~({hcbp_pkg::CODE_W{1'b1}} << in_i.code_len);
  assign code_masked = in_i.code_bits & len_mask;

  // Handshake: the read stage moves on once the drain buffer empties or its last byte is taken
  assign pop      = (cnt_q != '0) && out_o.ready;
  assign buf_free = (cnt_q == '0) || ((cnt_q == hcbp_pkg::CNT_W'(1)) && out_o.ready);
  assign s1_adv   = s1_vld_q && buf_free;
  assign in_i.ready = !s1_vld_q || s1_adv;

  // Table write on load, registered read on encode
  always_ff @(posedge clk_i) begin
    if (in_acc && is_load && in_range && len_ok) begin
      tab_mem[addr] <= {in_i.code_len, code_masked};
    end
    if (in_acc && is_encode) begin
      s1_rd_q <= tab_mem[addr];
    end
  end

  // Entry valid bits and read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_vld_q <= '0;
      s1_vld_q  <= 1'b0;
      s1_act_q  <= '0;
      s1_hit_q  <= 1'b0;
    end else begin
      if (in_acc && is_load && in_range && len_ok) begin
        tab_vld_q[addr] <= 1'b1;
      end
      if (in_acc) begin
        s1_vld_q <= 1'b1;
        s1_act_q <= in_i.action;
        s1_hit_q <= in_range && tab_vld_q[addr];
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  // Append the code to the pending bits and left-justify the result
  assign clen     = s1_rd_q[hcbp_pkg::CODE_W +: hcbp_pkg::LEN_W];
  assign code     = s1_rd_q[hcbp_pkg::CODE_W-1:0];
  assign acc      = (hcbp_pkg::ACC_W'(pend_q) << clen) | hcbp_pkg::ACC_W'(code);
  assign total    = hcbp_pkg::LEN_W'(pcnt_q) + clen;
  assign lj_shift = hcbp_pkg::LEN_W'(hcbp_pkg::LJ_W) - total;
  assign lj       = hcbp_pkg::LJ_W'(acc) << lj_shift;

  // Pack the word into the drain buffer, or shift the buffer on a pop
  always_comb begin
    pend_d = pend_q;
    pcnt_d = pcnt_q;
    cnt_d  = cnt_q;
    for (int i = 0; i < hcbp_pkg::MAX_BYTES; i++) begin
      buf_d[i] = (pop && (i + 1 < hcbp_pkg::MAX_BYTES)) ? buf_q[(i + 1) % hcbp_pkg::MAX_BYTES]
                                                        : buf_q[i];
    end
    if (pop) begin
      cnt_d = cnt_q - hcbp_pkg::CNT_W'(1);
    end
    if (s1_adv) begin
      cnt_d = '0;
      case (hcbp_pkg::action_e'(s1_act_q))
        hcbp_pkg::ACT_ENCODE: begin
          if (s1_hit_q && (clen != '0)) begin
            for (int k = 0; k < hcbp_pkg::MAX_BYTES; k++) begin
              buf_d[k] = lj[hcbp_pkg::LJ_W - 1 - BW * k -: BW];
            end
            cnt_d  = hcbp_pkg::CNT_W'(total >> 3);
            pend_d = acc[hcbp_pkg::PEND_W-1:0] &
                     ~({hcbp_pkg::PEND_W{1'b1}} << total[hcbp_pkg::PCNT_W-1:0]);
            pcnt_d = total[hcbp_pkg::PCNT_W-1:0];
          end
        end
        hcbp_pkg::ACT_FLUSH: begin
          if (pcnt_q != '0) begin
            buf_d[0] = BW'(pend_q) << (4'(BW) - 4'(pcnt_q));
            cnt_d    = hcbp_pkg::CNT_W'(1);
            pend_d   = '0;
            pcnt_d   = '0;
          end
        end
        default: begin
          // load and unused codes emit nothing
        end
      endcase
    end
  end

  // Hold the accumulator and buffer count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pcnt_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
      cnt_q  <= cnt_d;
    end
  end

  // Byte payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < hcbp_pkg::MAX_BYTES; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

  // Drive the output channel from the head of the buffer
  assign out_o.valid       = (cnt_q != '0);
  assign out_o.out_byte    = buf_q[0];
  assign out_o.last_of_run = (cnt_q == hcbp_pkg::CNT_W'(1));

endmodule

FILE: sv/hcbp_checker.sv
// Port-level checks for the Huffman code bit packer, bound to the top level.
// Depends on hcbp_pkg for the byte width.
module hcbp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [hcbp_pkg::BYTE_W-1:0] out_byte_i,
  input logic                        out_last_i
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("output word changed while stalled");

  // No output word while reset is applied
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // Bytes of one run come without gaps
  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("gap inside a run of output bytes");

  // An empty drain buffer never blocks the input
  a_ready_when_idle: assert property (@(posedge clk_i)
    !out_valid_i |-> in_ready_i)
    else $error("input refused with an empty output buffer");

  // An input word is stalled only while an output byte is pending
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i)
    else $error("input stalled with no output pending");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.last_of_run)
);
